>>> hdl/lmbrs_pkg.sv
// Shared types and constants for the LED matrix BCM row scanner.
`timescale 1ns / 1ps
package lmbrs_pkg;

  localparam int unsigned SHIFT_BITS  = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned ROW_W       = 5;
  localparam int unsigned PLANE_W     = 3;
  localparam int unsigned OE_W        = 11;
  localparam int unsigned BRIGHT_W    = 8;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Timer period in clock ticks of the panel timer.
  localparam logic [PERIOD_W-1:0] TIMER_PERIOD = 16'd1280;

  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(SHIFT_BITS - 1);

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_MASK  = 1'b1;

  // One tick's worth of work handed from the front to the back.
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic               shift;
    logic [PLANE_W-1:0] plane;
    logic [OE_W-1:0]    oe_compare;
  } cmd_t;

  // Output tdata layout, row_group in the lowest bits.
  typedef struct packed {
    logic [3:0]         pad;
    logic [OE_W-1:0]    oe_compare;
    logic [PLANE_W-1:0] plane;
    logic               serial_bit;
    logic [POS_W-1:0]   shift_position;
    logic [1:0]         row_group;
  } out_data_t;

endpackage

>>> hdl/lmbrs_front.sv
// Front end: takes ticks, steps plane and row counters, builds one command per tick.
`timescale 1ns / 1ps
module lmbrs_front import lmbrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_valid_i,
  input  logic                  tick_i,
  output logic                  tick_ready_o,
  input  logic [BRIGHT_W-1:0]   brightness_i,
  input  logic [ROW_W-1:0]      scan_mask_i,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [PLANE_W-1:0]  plane_q, plane_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                shifting;
  logic [PLANE_W-1:0]  next_plane;
  logic [PERIOD_W-1:0] weight;

  assign tick_ready_o = !full_i;
  assign shifting     = (plane_q == '0);
  assign next_plane   = plane_q + PLANE_W'(1);
  assign weight       = PERIOD_W'({7'd0, brightness_i} << next_plane);

  always_comb begin
    push_o  = tick_valid_i && !full_i && tick_i;
    plane_d = plane_q;
    row_d   = row_q;
    if (push_o) begin
      plane_d = next_plane;
      if (shifting) begin
        row_d = (row_q + ROW_W'(1)) & scan_mask_i;
      end
    end
    cmd_o.row   = row_q;
    cmd_o.shift = shifting;
    cmd_o.plane = next_plane;
    // Floor the compare value at zero when the weight reaches the period.
    if (weight >= TIMER_PERIOD) begin
      cmd_o.oe_compare = '0;
    end else begin
      cmd_o.oe_compare = OE_W'(TIMER_PERIOD - weight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
      row_q   <= '0;
    end else begin
      plane_q <= plane_d;
      row_q   <= row_d;
    end
  end

endmodule

>>> hdl/lmbrs_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module lmbrs_queue import lmbrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hdl/lmbrs_back.sv
// Back end: expands a command into one or eight result items behind an output register.
`timescale 1ns / 1ps
module lmbrs_back import lmbrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  cmd_t                  cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_data_t             out_data_o,
  output logic                  out_shift_o,
  output logic                  out_last_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  out_data_t        data_q, data_d;
  logic             shift_q;
  logic             last_q;
  logic             load;
  logic [POS_W-1:0] cur_pos;
  logic             cur_last;

  always_comb begin
    load     = valid_i && (!out_valid_q || out_ready_i);
    cur_pos  = cmd_i.shift ? pos_q : '0;
    cur_last = !cmd_i.shift || (pos_q == '0);
    pop_o    = load && cur_last;

    pos_d = pos_q;
    if (load) begin
      pos_d = cur_last ? POS_FIRST : pos_q - POS_W'(1);
    end

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    data_d.pad            = '0;
    data_d.oe_compare     = cmd_i.oe_compare;
    data_d.plane          = cmd_i.plane;
    data_d.serial_bit     = cmd_i.shift && (cmd_i.row[POS_W-1:0] == pos_q);
    data_d.shift_position = cur_pos;
    data_d.row_group      = cmd_i.row[ROW_W-1:ROW_W-2];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q  <= data_d;
      shift_q <= cmd_i.shift;
      last_q  <= cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = data_q;
  assign out_shift_o = shift_q;
  assign out_last_o  = last_q;

endmodule

>>> hdl/led_matrix_bcm_row_scanner.sv
// Top level of the LED matrix BCM row scanner.
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/tready        tdata[0] tick
//  m_axis    out        m_axis_tvalid/tready        tdata, tuser shift_valid, tlast last
//  cfg       in         cfg_we_i (no wait)          cfg_addr_i index, cfg_wdata_i value
//
// A tick item is taken whenever the two-entry command queue has room.
// A plane-zero tick yields eight items, one per cycle unless stalled; others yield one.
// The back end result sequencer sets the rate: one result item per cycle unless stalled.
// First result item goes through the command queue, then the back end output register.
// Reset clears plane and row counters and sets brightness 1, row mask 31.
// A stalled output holds its item while the front keeps taking ticks until the queue fills.
`timescale 1ns / 1ps
module led_matrix_bcm_row_scanner import lmbrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [0] tick
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] row_group, [4:2] shift_position, [5] serial_bit, [8:6] plane,
  // [19:9] oe_compare, [23:20] zero
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                   m_axis_tuser,   // [0] shift_valid
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [BRIGHT_W-1:0] brightness_q;
  logic [ROW_W-1:0]    scan_mask_q;
  logic                push;
  logic                full;
  logic                pop;
  logic                q_valid;
  cmd_t                push_cmd;
  cmd_t                head_cmd;
  out_data_t           out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHT_W'(1);
      scan_mask_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BRIGHTNESS: brightness_q <= cfg_wdata_i;
        REG_SCAN_MASK:  scan_mask_q  <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  lmbrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (s_axis_tvalid),
    .tick_i       (s_axis_tdata[0]),
    .tick_ready_o (s_axis_tready),
    .brightness_i (brightness_q),
    .scan_mask_i  (scan_mask_q),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  lmbrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  lmbrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data),
    .out_shift_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_data;

endmodule

>>> hdl/lmbrs_checker.sv
// Port-level checks on the row scanner result stream, bound to the top level.
`timescale 1ns / 1ps
module lmbrs_checker import lmbrs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped or changed while stalled");

  // A result without a shifter bit stands alone and carries no position or bit.
  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tlast && (m_axis_tdata[4:2] == 3'd0) && !m_axis_tdata[5])
    else $error("non-shift result malformed");

  // Shifter bits are only sent on the tick that leaves plane zero.
  a_shift_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[8:6] == 3'd1) && (m_axis_tlast == (m_axis_tdata[4:2] == 3'd0)))
    else $error("shift result on wrong plane or misplaced last");

  // Within a shift run the position counts down and the row group and compare value stay.
  a_shift_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tuser && (m_axis_tdata[4:2] == $past(m_axis_tdata[4:2]) - 3'd1) &&
      (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0])) &&
      (m_axis_tdata[19:9] == $past(m_axis_tdata[19:9])))
    else $error("shift run broken");

endmodule

bind led_matrix_bcm_row_scanner lmbrs_checker u_lmbrs_checker (.*);
